FILE: rtl/bsaw_pkg.sv
// ----------------------------------------------------------------------------
// bsaw_pkg
// Shared widths, register indexes, status type and slot helper for the
// broadcast strided address walk.
// ----------------------------------------------------------------------------
`default_nettype none

package bsaw_pkg;

	localparam int SLOTS      = 4;   // size and stride slots held per register
	localparam int SLOT_W     = 16;  // width of one size or stride slot
	localparam int CFG_W      = 64;  // width of the configuration data bus
	localparam int RANK_W     = 3;   // width of a rank register
	localparam int CFG_IDX_W  = 3;   // width of the register index
	localparam int OUT_ADDR_W = 16;  // width of the address result fields

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_SIZES    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SIZES   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_STRIDES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_STRIDES = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_BASE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BASE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_RANK     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_RANK    = 3'd7;

	// per-transaction flags travelling with the walk position
	typedef struct packed {
		logic last;
		logic empty;
	} walk_status_t;

	// 16-bit slot k of a packed size or stride register
	function automatic logic [SLOT_W-1:0] slot_of(input logic [CFG_W-1:0] r,
		input int unsigned k);
		return r[k*SLOT_W +: SLOT_W];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bsaw_walk_ctrl.sv
// ----------------------------------------------------------------------------
// bsaw_walk_ctrl
// Level counters of the walk: loop counts, end detection, carry advance and
// the registered walk position handed to the address datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bsaw_walk_ctrl #(
	parameter int LEVELS = 4
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           en,
	input  wire logic                                           restart,
	input  wire logic [bsaw_pkg::CFG_W-1:0]                     left_sizes,
	input  wire logic [bsaw_pkg::CFG_W-1:0]                     right_sizes,
	input  wire logic [bsaw_pkg::RANK_W-1:0]                    left_rank,
	input  wire logic [bsaw_pkg::RANK_W-1:0]                    right_rank,
	output logic      [LEVELS-1:0][bsaw_pkg::SLOT_W-1:0]        pos_s1,
	output bsaw_pkg::walk_status_t                              status_s1
);
	import bsaw_pkg::*;

	logic [LEVELS-1:0][SLOT_W-1:0] cnt_q;
	logic [LEVELS-1:0][SLOT_W-1:0] cur;
	logic [LEVELS-1:0][SLOT_W-1:0] nxt;
	logic [LEVELS-1:0][SLOT_W-1:0] count;
	logic [LEVELS-1:0]             active;
	logic [LEVELS-1:0]             at_end;
	logic [SLOT_W-1:0]             ls;
	logic [SLOT_W-1:0]             rs;
	logic                          carry;
	walk_status_t                  status;

	// level k < LEVELS is inside a clamped rank exactly when it is inside the raw rank
	always_comb begin
		ls     = '0;
		rs     = '0;
		carry  = 1'b1;
		status = '0;
		for (int k = 0; k < LEVELS; k++) begin
			ls = (RANK_W'(k) < left_rank)  ? slot_of(left_sizes, k)  : SLOT_W'(1);
			rs = (RANK_W'(k) < right_rank) ? slot_of(right_sizes, k) : SLOT_W'(1);
			count[k]  = (ls > rs) ? ls : rs;
			active[k] = (RANK_W'(k) < left_rank) || (RANK_W'(k) < right_rank);
			cur[k]    = restart ? '0 : cnt_q[k];
			at_end[k] = ({1'b0, cur[k]} + (SLOT_W+1)'(1)) >= {1'b0, count[k]};
		end
		for (int k = 0; k < LEVELS; k++) begin
			if (active[k] && count[k] == '0)
				status.empty = 1'b1;
		end
		status.last = &(~active | at_end);
		// innermost loop is the highest active level
		nxt = cur;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if (active[k] && carry) begin
				if (!at_end[k]) begin
					nxt[k] = cur[k] + SLOT_W'(1);
					carry  = 1'b0;
				end else begin
					nxt[k] = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en) begin
			cnt_q <= status.empty ? cur : nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1    <= cur;
			status_s1 <= status;
		end
	end

	a_restart_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		en && restart |=> pos_s1 == '0)
		else $error("walk position not cleared after restart");

	a_empty_holds_counters: assert property (@(posedge clk) disable iff (!arst_n)
		en && status.empty |=> cnt_q == $past(cur))
		else $error("counters moved on an empty walk");

	a_no_levels_single_pair: assert property (@(posedge clk) disable iff (!arst_n)
		active == '0 |-> status.last && !status.empty)
		else $error("walk without levels not a single last pair");

endmodule

`default_nettype wire

FILE: rtl/broadcast_strided_address_walk_top.sv
// ----------------------------------------------------------------------------
// broadcast_strided_address_walk_top
// Address pair generator for an in-place broadcast elementwise operation on
// two strided tensors of rank up to four.
// ----------------------------------------------------------------------------
// usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes sizes,
//    strides, bases and ranks; cfg_ready is always high; the user must
//    rewrite registers only while no transaction is in flight (not enforced)
//  - each input transaction (restart) yields one output transaction:
//    left_address, right_address, last_pair, empty_walk
//  - restart = 1 begins a new walk at its first pair; after the last pair
//    the walk wraps back to its start
//  - a result passes the three registers of counter step, per-level
//    multiply and base-plus-products sum before out_valid rises; one
//    transaction per cycle is sustained while out_ready stays high
//  - when out_ready is low the pipe holds; in_ready stays high while any
//    stage has a free slot, so up to three transactions can be buffered
//  - reset clears configuration, level counters and all valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module broadcast_strided_address_walk_top #(
	parameter int MAX_RANK     = 4,
	parameter int ADDRESS_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bsaw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bsaw_pkg::CFG_W-1:0]          cfg_data,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                restart,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [bsaw_pkg::OUT_ADDR_W-1:0]     left_address,
	output logic      [bsaw_pkg::OUT_ADDR_W-1:0]     right_address,
	output logic                                     last_pair,
	output logic                                     empty_walk
);
	import bsaw_pkg::*;

	// hardware levels: rank saturates at the smaller of MAX_RANK and the slot count
	localparam int LEVELS = (MAX_RANK < SLOTS) ? MAX_RANK : SLOTS;

	// configuration registers
	logic [CFG_W-1:0]  left_sizes_q;
	logic [CFG_W-1:0]  right_sizes_q;
	logic [CFG_W-1:0]  left_strides_q;
	logic [CFG_W-1:0]  right_strides_q;
	logic [SLOT_W-1:0] left_base_q;
	logic [SLOT_W-1:0] right_base_q;
	logic [RANK_W-1:0] left_rank_q;
	logic [RANK_W-1:0] right_rank_q;

	// pipe control
	logic v1_q;
	logic v2_q;
	logic out_valid_q;
	logic adv2;
	logic adv3;
	logic accept;

	// stage 1: walk position from the counter block
	logic [LEVELS-1:0][SLOT_W-1:0] pos_s1;
	walk_status_t                  status_s1;

	// stage 2: per-level products
	logic [LEVELS-1:0][ADDRESS_BITS-1:0] lprod_s2;
	logic [LEVELS-1:0][ADDRESS_BITS-1:0] rprod_s2;
	walk_status_t                        status_s2;

	// effective strides and products
	logic [LEVELS-1:0][SLOT_W-1:0]     lstep;
	logic [LEVELS-1:0][SLOT_W-1:0]     rstep;
	logic [LEVELS-1:0][2*SLOT_W-1:0]   lfull;
	logic [LEVELS-1:0][2*SLOT_W-1:0]   rfull;

	// stage 3: sums and output register
	logic [ADDRESS_BITS-1:0]            lsum;
	logic [ADDRESS_BITS-1:0]            rsum;
	logic [SLOT_W+ADDRESS_BITS-1:0]     lbase_wide;
	logic [SLOT_W+ADDRESS_BITS-1:0]     rbase_wide;
	logic [OUT_ADDR_W+ADDRESS_BITS-1:0] lsum_wide;
	logic [OUT_ADDR_W+ADDRESS_BITS-1:0] rsum_wide;
	logic [OUT_ADDR_W-1:0]              left_addr_q;
	logic [OUT_ADDR_W-1:0]              right_addr_q;
	logic                               last_q;
	logic                               empty_q;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sizes_q    <= '0;
			right_sizes_q   <= '0;
			left_strides_q  <= '0;
			right_strides_q <= '0;
			left_base_q     <= '0;
			right_base_q    <= '0;
			left_rank_q     <= '0;
			right_rank_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEFT_SIZES:    left_sizes_q    <= cfg_data;
				REG_RIGHT_SIZES:   right_sizes_q   <= cfg_data;
				REG_LEFT_STRIDES:  left_strides_q  <= cfg_data;
				REG_RIGHT_STRIDES: right_strides_q <= cfg_data;
				REG_LEFT_BASE:     left_base_q     <= cfg_data[SLOT_W-1:0];
				REG_RIGHT_BASE:    right_base_q    <= cfg_data[SLOT_W-1:0];
				REG_LEFT_RANK:     left_rank_q     <= cfg_data[RANK_W-1:0];
				REG_RIGHT_RANK:    right_rank_q    <= cfg_data[RANK_W-1:0];
			endcase
		end
	end

	// each stage moves when the next one is empty or moving
	assign adv3     = !out_valid_q || out_ready;
	assign adv2     = !v2_q || adv3;
	assign in_ready = !v1_q || adv2;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				v1_q <= in_valid;
			if (adv2)
				v2_q <= v1_q;
			if (adv3)
				out_valid_q <= v2_q;
		end
	end

	// counter step: position snapshot and walk flags land in stage 1
	bsaw_walk_ctrl #(
		.LEVELS (LEVELS)
	) u_walk_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.restart     (restart),
		.left_sizes  (left_sizes_q),
		.right_sizes (right_sizes_q),
		.left_rank   (left_rank_q),
		.right_rank  (right_rank_q),
		.pos_s1      (pos_s1),
		.status_s1   (status_s1)
	);

	// an address moves at a level only where its own size exceeds one
	always_comb begin
		for (int k = 0; k < LEVELS; k++) begin
			lstep[k] = ((RANK_W'(k) < left_rank_q) && (slot_of(left_sizes_q, k) > SLOT_W'(1)))
				? slot_of(left_strides_q, k) : '0;
			rstep[k] = ((RANK_W'(k) < right_rank_q) && (slot_of(right_sizes_q, k) > SLOT_W'(1)))
				? slot_of(right_strides_q, k) : '0;
			lfull[k] = (2*SLOT_W)'(pos_s1[k]) * (2*SLOT_W)'(lstep[k]);
			rfull[k] = (2*SLOT_W)'(pos_s1[k]) * (2*SLOT_W)'(rstep[k]);
		end
	end

	// stage 2: one 16x16 multiply per level and tensor
	always_ff @(posedge clk) begin
		if (v1_q && adv2) begin
			for (int k = 0; k < LEVELS; k++) begin
				lprod_s2[k] <= lfull[k][ADDRESS_BITS-1:0];
				rprod_s2[k] <= rfull[k][ADDRESS_BITS-1:0];
			end
			status_s2 <= status_s1;
		end
	end

	// base plus products, wrapping at ADDRESS_BITS
	always_comb begin
		lbase_wide = {{ADDRESS_BITS{1'b0}}, left_base_q};
		rbase_wide = {{ADDRESS_BITS{1'b0}}, right_base_q};
		lsum = lbase_wide[ADDRESS_BITS-1:0];
		rsum = rbase_wide[ADDRESS_BITS-1:0];
		for (int k = 0; k < LEVELS; k++) begin
			lsum = lsum + lprod_s2[k];
			rsum = rsum + rprod_s2[k];
		end
		lsum_wide = {{OUT_ADDR_W{1'b0}}, lsum};
		rsum_wide = {{OUT_ADDR_W{1'b0}}, rsum};
	end

	// stage 3: output register, addresses forced to zero and last set on an empty walk
	always_ff @(posedge clk) begin
		if (v2_q && adv3) begin
			left_addr_q  <= status_s2.empty ? '0 : lsum_wide[OUT_ADDR_W-1:0];
			right_addr_q <= status_s2.empty ? '0 : rsum_wide[OUT_ADDR_W-1:0];
			last_q       <= status_s2.last || status_s2.empty;
			empty_q      <= status_s2.empty;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_address  = left_addr_q;
	assign right_address = right_addr_q;
	assign last_pair     = last_q;
	assign empty_walk    = empty_q;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_empty_result_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_walk |-> last_pair && left_address == '0 && right_address == '0)
		else $error("empty walk result not in canonical form");

	a_result_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_address)
			&& $stable(right_address) && $stable(last_pair) && $stable(empty_walk))
		else $error("output transaction changed while stalled");

endmodule

`default_nettype wire
